[hw/rtl/kwm_pkg.sv]
package kwm_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_TAKE = 1'b1
    } t_action;

    typedef struct packed {
        logic push;
        logic take_start;
        logic rd_en;
        logic finish;
    } t_cmd;

    localparam int LANE_FIELD_W  = 3;
    localparam int VALUE_FIELD_W = 32;

endpackage

[hw/rtl/kwm_ctrl.sv]
module kwm_ctrl #(
    parameter int LANES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    output kwm_pkg::t_cmd       o_cmd,
    output logic [$clog2(LANES)-1:0] o_rd_lane
);
    import kwm_pkg::*;

    localparam int LW = $clog2(LANES);
    localparam int IW = LW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(LANES);

    t_state          r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            w_ready;
    logic            w_accept;

    assign w_ready    = (r_state == S_IDLE) && (!i_out_valid || !i_out_stall);
    assign w_accept   = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;
    assign o_rd_lane  = r_idx[LW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_action == ACT_TAKE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.push       = 1'b0;
        o_cmd.take_start = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.finish     = 1'b0;
        n_idx            = r_idx;
        case (r_state)
            S_IDLE: begin
                o_cmd.push       = w_accept && (i_action == ACT_PUSH);
                o_cmd.take_start = w_accept && (i_action == ACT_TAKE);
                n_idx            = '0;
            end
            S_SCAN: begin
                o_cmd.rd_en = (r_idx < LAST_IDX);
                n_idx       = r_idx + IW'(1);
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_take_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_start |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("Take did not start a scan from lane zero.");

    a_finish_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> $past(r_state) == S_SCAN)
        else $error("Finish was reached without a scan.");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("Input accepted while a take was in progress.");

endmodule

[hw/rtl/kwm_dp.sv]
module kwm_dp #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kwm_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(LANES)-1:0]             i_rd_lane,
    input  logic [kwm_pkg::LANE_FIELD_W-1:0]     i_lane,
    input  logic signed [kwm_pkg::VALUE_FIELD_W-1:0] i_element_value,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [kwm_pkg::VALUE_FIELD_W-1:0] o_result_value,
    output logic [kwm_pkg::LANE_FIELD_W-1:0]     o_source_lane,
    output logic                                 o_all_empty,
    output logic                                 o_push_rejected
);
    import kwm_pkg::*;

    localparam int LW        = $clog2(LANES);
    localparam int HW        = $clog2(LANE_DEPTH);
    localparam int CW        = $clog2(LANE_DEPTH + 1);
    localparam int SW        = HW + 1;
    localparam int MEM_DEPTH = LANES * LANE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [31:0]  LANES_W  = 32'(LANES);
    localparam logic [CW-1:0] DEPTH_C = CW'(LANE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(LANE_DEPTH);
    localparam logic [HW-1:0] HEAD_LAST = HW'(LANE_DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_A = AW'(LANE_DEPTH);

    logic signed [VALUE_FIELD_W-1:0] r_mem [MEM_DEPTH];
    logic [HW-1:0]  r_head [LANES];
    logic [CW-1:0]  r_fill [LANES];

    logic [LW-1:0]  w_idx;
    logic [HW-1:0]  w_head;
    logic [CW-1:0]  w_fill;
    logic [SW-1:0]  w_sum;
    logic [HW-1:0]  w_slot;
    logic [AW-1:0]  w_base;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;
    logic           w_push_ok;
    logic [HW-1:0]  w_head_inc;

    logic                            r_rd_valid;
    logic [LW-1:0]                   r_rd_lane;
    logic signed [VALUE_FIELD_W-1:0] r_rd_data;
    logic                            r_found;
    logic [LW-1:0]                   r_best_lane;
    logic signed [VALUE_FIELD_W-1:0] r_best_val;
    logic                            r_out_valid;

    always_comb begin
        if (i_cmd.push) begin
            w_idx = LW'(i_lane);
        end else if (i_cmd.rd_en) begin
            w_idx = i_rd_lane;
        end else begin
            w_idx = r_best_lane;
        end
    end

    assign w_head     = r_head[w_idx];
    assign w_fill     = r_fill[w_idx];
    assign w_sum      = SW'(w_head) + SW'(w_fill);
    assign w_slot     = (w_sum >= DEPTH_S) ? HW'(w_sum - DEPTH_S) : HW'(w_sum);
    assign w_base     = AW'(w_idx) * DEPTH_A;
    assign w_wr_addr  = w_base + AW'(w_slot);
    assign w_rd_addr  = w_base + AW'(w_head);
    assign w_push_ok  = (32'(i_lane) < LANES_W) && (w_fill < DEPTH_C);
    assign w_head_inc = (w_head == HEAD_LAST) ? '0 : w_head + HW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && w_push_ok) begin
            r_mem[w_wr_addr] <= i_element_value;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_cmd.push && w_push_ok) begin
            r_fill[w_idx] <= w_fill + CW'(1);
        end else if (i_cmd.finish && r_found) begin
            r_head[w_idx] <= w_head_inc;
            r_fill[w_idx] <= w_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en && (w_fill != '0);
            if (i_cmd.take_start) begin
                r_found <= 1'b0;
            end else if (r_rd_valid && (!r_found || (r_rd_data < r_best_val))) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_lane <= i_rd_lane;
        if (!i_rst_n) begin
            r_best_lane <= '0;
        end else if (r_rd_valid && (!r_found || (r_rd_data < r_best_val))) begin
            r_best_lane <= r_rd_lane;
            r_best_val  <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_result_value  <= '0;
            o_source_lane   <= '0;
            o_all_empty     <= 1'b0;
            o_push_rejected <= !w_push_ok;
        end else if (i_cmd.finish) begin
            o_result_value  <= r_found ? r_best_val : '0;
            o_source_lane   <= r_found ? LANE_FIELD_W'(r_best_lane) : '0;
            o_all_empty     <= !r_found;
            o_push_rejected <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_push_output_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || !i_out_stall))
        else $error("Push result would overwrite a pending result.");

    a_finish_output_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || !i_out_stall))
        else $error("Take result would overwrite a pending result.");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= DEPTH_C)
        else $error("Lane fill count exceeds the lane depth.");

endmodule

[hw/rtl/k_way_sorted_merge.sv]
// A push result is registered in the cycle after the push is accepted.
// A take scans the lanes, reading one lane head per cycle from the lane memory
// through a registered read, then commits the chosen head in a finish state.
// One transaction is in progress at a time; results sit in an output register.
// Reset is synchronous and active low; it empties every lane and clears control state.
module k_way_sorted_merge #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_action,
    input  logic [kwm_pkg::LANE_FIELD_W-1:0]         i_lane,
    input  logic signed [kwm_pkg::VALUE_FIELD_W-1:0] i_element_value,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [kwm_pkg::VALUE_FIELD_W-1:0] o_result_value,
    output logic [kwm_pkg::LANE_FIELD_W-1:0]         o_source_lane,
    output logic                                     o_all_empty,
    output logic                                     o_push_rejected
);
    import kwm_pkg::*;

    t_cmd                     w_cmd;
    logic [$clog2(LANES)-1:0] w_rd_lane;

    kwm_ctrl #(
        .LANES (LANES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .o_rd_lane   (w_rd_lane)
    );

    kwm_dp #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rd_lane       (w_rd_lane),
        .i_lane          (i_lane),
        .i_element_value (i_element_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_value  (o_result_value),
        .o_source_lane   (o_source_lane),
        .o_all_empty     (o_all_empty),
        .o_push_rejected (o_push_rejected)
    );

endmodule

[tb/kwm_merge_checker.sv]
`timescale 1ns / 100ps

module kwm_merge_checker #(
    parameter int LANES      = 8,
    parameter int LANE_DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  logic                                     i_in_stall,
    input  logic                                     i_action,
    input  logic [kwm_pkg::LANE_FIELD_W-1:0]         i_lane,
    input  logic signed [kwm_pkg::VALUE_FIELD_W-1:0] i_element_value,
    input  logic                                     i_out_valid,
    input  logic                                     i_out_stall,
    input  logic signed [kwm_pkg::VALUE_FIELD_W-1:0] i_result_value,
    input  logic [kwm_pkg::LANE_FIELD_W-1:0]         i_source_lane,
    input  logic                                     i_all_empty,
    input  logic                                     i_push_rejected,
    output int                                       o_err_cnt,
    output int                                       o_pending
);

    import kwm_pkg::*;

    localparam int PTR_W = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int CNT_W = $clog2(LANE_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value;
        logic [LANE_FIELD_W-1:0]  lane;
        logic                     empty;
        logic                     rejected;
    } t_merge_res;

    logic signed [VALUE_FIELD_W-1:0] lane_mem [LANES][LANE_DEPTH];
    logic [PTR_W-1:0]                head_idx [LANES];
    logic [CNT_W-1:0]                depth_cnt [LANES];
    t_merge_res                      merge_q [$];
    int                              errs = 0;

    function automatic t_merge_res merge_step(t_action act, logic [LANE_FIELD_W-1:0] ln,
                                              logic signed [VALUE_FIELD_W-1:0] val);
        t_merge_res                      res;
        logic                            found;
        int                              best;
        logic signed [VALUE_FIELD_W-1:0] best_val;
        res = '0;
        found = 1'b0;
        best = 0;
        best_val = '0;
        if (act == ACT_PUSH) begin
            if (ln >= LANES || depth_cnt[ln] >= LANE_DEPTH) begin
                res.rejected = 1'b1;
            end else begin
                lane_mem[ln][(head_idx[ln] + depth_cnt[ln]) % LANE_DEPTH] = val;
                depth_cnt[ln] = depth_cnt[ln] + 1'b1;
            end
        end else begin
            // Only a strictly smaller head replaces the minimum, so the lowest lane wins ties.
            for (int i = 0; i < LANES; i++) begin
                if (depth_cnt[i] != 0 && (!found || lane_mem[i][head_idx[i]] < best_val)) begin
                    found = 1'b1;
                    best = i;
                    best_val = lane_mem[i][head_idx[i]];
                end
            end
            if (!found) begin
                res.empty = 1'b1;
            end else begin
                head_idx[best] = PTR_W'((head_idx[best] + 1) % LANE_DEPTH);
                depth_cnt[best] = depth_cnt[best] - 1'b1;
                res.value = best_val;
                res.lane = best[LANE_FIELD_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_merge_res got;
        t_merge_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                head_idx[i] = '0;
                depth_cnt[i] = '0;
            end
            merge_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                merge_q.push_back(merge_step(t_action'(i_action), i_lane, i_element_value));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_result_value, i_source_lane, i_all_empty, i_push_rejected};
                if (merge_q.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("%0t: result with no transaction pending: value %0d lane %0d "
                                 , $time, $signed(got.value), got.lane,
                                 "empty %0b rejected %0b", got.empty, got.rejected);
                    end
                end else begin
                    want = merge_q.pop_front();
                    if (got !== want) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("%0t: result mismatch: value %0d/%0d lane %0d/%0d ",
                                     $time, $signed(want.value), $signed(got.value),
                                     want.lane, got.lane,
                                     "empty %0b/%0b rejected %0b/%0b (expected/actual)",
                                     want.empty, got.empty, want.rejected, got.rejected);
                        end
                    end
                end
            end
        end
        o_pending <= merge_q.size();
        o_err_cnt <= errs;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    import kwm_pkg::*;

    localparam int LANES      = 8;
    localparam int LANE_DEPTH = 64;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = LANES + 3 + 20;

    localparam logic signed [VALUE_FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum {
        VAL_MIXED,
        VAL_SORTED
    } t_val_mode;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    t_action                          in_action;
    logic [LANE_FIELD_W-1:0]          in_lane;
    logic signed [VALUE_FIELD_W-1:0]  in_value;
    logic                             out_valid;
    logic                             out_stall;
    logic signed [VALUE_FIELD_W-1:0]  res_value;
    logic [LANE_FIELD_W-1:0]          res_lane;
    logic                             res_empty;
    logic                             res_rejected;
    int                               err_cnt;
    int                               pending;

    logic                             tx_idle_on = 1'b1;
    logic                             rx_idle_on = 1'b1;
    logic                             hold_req = 1'b0;
    logic signed [VALUE_FIELD_W-1:0]  lane_tail [8];

    k_way_sorted_merge #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (in_action),
        .i_lane          (in_lane),
        .i_element_value (in_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_value  (res_value),
        .o_source_lane   (res_lane),
        .o_all_empty     (res_empty),
        .o_push_rejected (res_rejected)
    );

    kwm_merge_checker #(
        .LANES      (LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_action        (in_action),
        .i_lane          (in_lane),
        .i_element_value (in_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result_value  (res_value),
        .i_source_lane   (res_lane),
        .i_all_empty     (res_empty),
        .i_push_rejected (res_rejected),
        .o_err_cnt       (err_cnt),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // The receiver stalls in short random bursts, or once for a long stretch on request.
    initial begin
        out_stall = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic send_txn(t_action act, logic [LANE_FIELD_W-1:0] ln,
                            logic signed [VALUE_FIELD_W-1:0] val);
        in_valid <= 1'b1;
        in_action <= act;
        in_lane <= ln;
        in_value <= val;
        do @(posedge clk); while (in_stall);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic run_phase(int n_items, int take_pct, int lane_hi, t_val_mode mode,
                             logic idle_ok);
        logic [LANE_FIELD_W-1:0]         ln;
        logic signed [VALUE_FIELD_W-1:0] val;
        int                              pick;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                tx_idle_on = idle_ok && ($urandom_range(0, 2) != 0);
            end
            ln = ($urandom_range(0, 9) == 0) ? LANE_FIELD_W'($urandom_range(0, 7))
                                             : LANE_FIELD_W'($urandom_range(0, lane_hi));
            pick = $urandom_range(0, 9);
            if (mode == VAL_SORTED && pick != 0) begin
                lane_tail[ln] = lane_tail[ln] + $urandom_range(0, 2);
                val = lane_tail[ln];
            end else if (pick == 1) begin
                val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            end else if (pick <= 3) begin
                val = $signed($urandom_range(0, 6)) - 3;
            end else begin
                val = $urandom;
            end
            if ($urandom_range(1, 100) <= take_pct) begin
                send_txn(ACT_TAKE, ln, val);
            end else begin
                send_txn(ACT_PUSH, ln, val);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_action = ACT_PUSH;
        in_lane = '0;
        in_value = '0;
        for (int i = 0; i < 8; i++) begin
            lane_tail[i] = -20;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, ties between lanes, and takes from an empty block.
        send_txn(ACT_TAKE, 3'd5, VAL_MAX);
        send_txn(ACT_PUSH, 3'd7, VAL_MAX);
        send_txn(ACT_PUSH, 3'd0, VAL_MIN);
        send_txn(ACT_PUSH, 3'd3, -1);
        send_txn(ACT_PUSH, 3'd5, 5);
        send_txn(ACT_PUSH, 3'd2, 5);
        send_txn(ACT_PUSH, 3'd3, 5);
        send_txn(ACT_PUSH, 3'd4, VAL_MAX);
        for (int i = 0; i < 8; i++) begin
            send_txn(ACT_TAKE, 3'(i), $urandom);
        end
        send_txn(ACT_PUSH, 3'd1, 0);
        send_txn(ACT_TAKE, 3'd7, VAL_MIN);
        wait_drained();

        run_phase(250, 50, 7, VAL_MIXED, 1'b1);

        // A long receiver hold, which stalls the input; then pushes pile mostly onto two lanes until they are full.
        hold_req = 1'b1;
        run_phase(250, 15, 1, VAL_MIXED, 1'b1);
        wait_drained();

        run_phase(250, 85, 7, VAL_MIXED, 1'b1);
        run_phase(350, 45, 7, VAL_SORTED, 1'b1);
        wait_drained();
        run_phase(150, 55, 3, VAL_SORTED, 1'b1);

        rx_idle_on = 1'b0;
        run_phase(250, 50, 7, VAL_MIXED, 1'b0);
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (err_cnt == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/kwm_dp.sv
hw/rtl/k_way_sorted_merge.sv
tb/kwm_merge_checker.sv
tb/tb.sv
